// ===== hdl/mhkt_pkg.sv =====
`timescale 1ns / 1ps
package mhkt_pkg;
  localparam int PLY_LIMIT   = 128;
  localparam int PIECE_KINDS = 8;
  localparam int MOVE_WIDTH  = 32;
  localparam int HIST_SIZE   = 2 * PIECE_KINDS * 64;
  localparam int KILL_SIZE   = PLY_LIMIT * 2;
  localparam int HIST_AW     = $clog2(HIST_SIZE);
  localparam int KILL_AW     = $clog2(KILL_SIZE);
  localparam int PLY_AW      = (PLY_LIMIT > 1) ? $clog2(PLY_LIMIT) : 1;
  localparam int CLEAR_AW    = HIST_AW + 1;
  localparam int DIV_STEPS   = 24;

  localparam logic [1:0] OP_CUTOFF = 2'd0;
  localparam logic [1:0] OP_QUIET  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [0:0] REG_BAD_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_UNSEARCHED    = 1'd1;

  localparam logic [6:0] BAD_THRESHOLD_RESET = 7'd60;
  localparam logic [6:0] UNSEARCHED_RESET    = 7'd100;
  localparam logic [6:0] PERCENT_MAX         = 7'd100;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  function automatic logic [HIST_AW-1:0] hist_index(input logic side, input logic [2:0] piece,
                                                    input logic [5:0] square);
    logic [31:0] p;
    logic [31:0] full;
    p = 32'(piece) % PIECE_KINDS;
    full = ((32'(side) * PIECE_KINDS) + p) * 64 + 32'(square);
    return full[HIST_AW-1:0];
  endfunction
endpackage

// ===== hdl/mhkt_ram.sv =====
`timescale 1ns / 1ps
module mhkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/move_history_killer_table.sv =====
`timescale 1ns / 1ps
// updates pass through S_READ, S_WAIT and S_UPDATE; queries then run 24 steps of one shared
// restoring divide/subtract unit (S_DIV) and finish in S_DONE; busy stays high the whole time
// a new request is taken only in S_IDLE, once busy is low again
// reset: clears control, then a clearing pass over all stores with busy high
// here the receiver cannot stall: out_valid is high for exactly one cycle per request
module move_history_killer_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic        in_side,
  input  logic [6:0]  in_ply_index,
  input  logic [31:0] in_move_word,
  input  logic [2:0]  in_move_piece,
  input  logic [5:0]  in_move_square,
  input  logic        in_query_prev_side,
  input  logic [2:0]  in_prev_piece,
  input  logic [5:0]  in_prev_square,
  output logic        out_valid,
  output logic        out_killer_hit,
  output logic        out_counter_hit,
  output logic [6:0]  out_pruning_margin,
  output logic [6:0]  out_cutoff_percent,
  output logic        out_bad_history,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int HAW = mhkt_pkg::HIST_AW;
  localparam int KAW = mhkt_pkg::KILL_AW;
  localparam int MW  = mhkt_pkg::MOVE_WIDTH;
  localparam int PLY_AW_W = mhkt_pkg::PLY_AW;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_UPDATE, S_DIV, S_DONE} state_t;

  state_t state_r;
  logic [mhkt_pkg::CLEAR_AW-1:0] clr_r;
  logic [6:0] thr_r, unm_r;
  logic [1:0] op_r;
  logic [MW-1:0] mv_r;
  logic [HAW-1:0] hidx_r, ridx_r;
  logic [KAW-1:0] kidx_r;
  logic [4:0] step_r;
  logic [23:0] quo_r;
  logic [16:0] rem_r;
  logic [15:0] srch_r;
  logic kh_r, ch_r;

  // ram ports
  logic h_we, k_we, r_we;
  logic [HAW-1:0] h_waddr, h_raddr, r_waddr, r_raddr;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [31:0] h_wdata, h_rdata;
  logic [2*MW-1:0] k_wdata, k_rdata, r_wdata, r_rdata;

  mhkt_ram #(.WIDTH(32), .DEPTH(mhkt_pkg::HIST_SIZE)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));
  mhkt_ram #(.WIDTH(2*MW), .DEPTH(mhkt_pkg::KILL_SIZE)) u_kill (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));
  mhkt_ram #(.WIDTH(2*MW), .DEPTH(mhkt_pkg::HIST_SIZE)) u_reply (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));

  logic accept;
  logic [PLY_AW_W-1:0] ply_m;
  logic [31:0] ply_full;
  logic [15:0] s_cur, c_cur, s_pre, c_pre;
  logic [MW-1:0] kp, ks, rp, rs;
  logic [16:0] trial;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign cfg_pready = 1'b1;
  assign ply_full = 32'(in_ply_index) % mhkt_pkg::PLY_LIMIT;
  assign ply_m = ply_full[PLY_AW_W-1:0];

  assign s_cur = h_rdata[15:0];
  assign c_cur = h_rdata[31:16];
  assign s_pre = (s_cur == mhkt_pkg::COUNT_MAX) ? (s_cur >> 4) : s_cur;
  assign c_pre = (s_cur == mhkt_pkg::COUNT_MAX) ? (c_cur >> 4) : c_cur;
  assign kp = k_rdata[MW-1:0];
  assign ks = k_rdata[2*MW-1:MW];
  assign rp = r_rdata[MW-1:0];
  assign rs = r_rdata[2*MW-1:MW];
  assign trial = {rem_r[15:0], quo_r[23]} - {1'b0, srch_r};

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == mhkt_pkg::REG_UNSEARCHED) begin
      cfg_prdata = {25'd0, unm_r};
    end else begin
      cfg_prdata = {25'd0, thr_r};
    end
  end

  always_comb begin
    h_raddr = hidx_r;
    k_raddr = kidx_r;
    r_raddr = ridx_r;
    h_we = 1'b0; k_we = 1'b0; r_we = 1'b0;
    h_waddr = hidx_r; k_waddr = kidx_r; r_waddr = ridx_r;
    h_wdata = 32'd0; k_wdata = '0; r_wdata = '0;
    if (state_r == S_CLEAR) begin
      h_we = 1'b1; k_we = 1'b1; r_we = 1'b1;
      h_waddr = clr_r[HAW-1:0];
      r_waddr = clr_r[HAW-1:0];
      k_waddr = clr_r[KAW-1:0];
    end else if (state_r == S_UPDATE && op_r != mhkt_pkg::OP_UNUSED &&
                 op_r != mhkt_pkg::OP_QUERY) begin
      h_we = 1'b1;
      h_wdata = {(op_r == mhkt_pkg::OP_CUTOFF) ? c_pre + 16'd1 : c_pre, s_pre + 16'd1};
      if (op_r == mhkt_pkg::OP_CUTOFF) begin
        k_we = (kp != mv_r);
        k_wdata = {kp, mv_r};
        r_we = (rp != mv_r);
        r_wdata = {rp, mv_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      thr_r <= mhkt_pkg::BAD_THRESHOLD_RESET;
      unm_r <= mhkt_pkg::UNSEARCHED_RESET;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_DONE) ||
                   (state_r == S_UPDATE && op_r != mhkt_pkg::OP_QUERY);
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == mhkt_pkg::REG_UNSEARCHED) begin
          unm_r <= cfg_pwdata[6:0];
        end else begin
          thr_r <= cfg_pwdata[6:0];
        end
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == mhkt_pkg::CLEAR_AW'(mhkt_pkg::HIST_SIZE - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r <= in_opcode;
            mv_r <= in_move_word[MW-1:0];
            hidx_r <= mhkt_pkg::hist_index(in_side, in_move_piece, in_move_square);
            kidx_r <= KAW'({ply_m, in_side});
            ridx_r <= mhkt_pkg::hist_index(
                (in_opcode == mhkt_pkg::OP_QUERY) ? in_query_prev_side : !in_side,
                in_prev_piece, in_prev_square);
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_WAIT;
        S_WAIT: state_r <= S_UPDATE;
        S_UPDATE: begin
          kh_r <= (kp == mv_r) || (ks == mv_r);
          ch_r <= (rp == mv_r) || (rs == mv_r);
          srch_r <= s_cur;
          quo_r <= 24'(c_cur) * 24'd100;
          rem_r <= '0;
          step_r <= '0;
          if (op_r == mhkt_pkg::OP_QUERY) begin
            state_r <= S_DIV;
          end else begin
            out_killer_hit <= 1'b0;
            out_counter_hit <= 1'b0;
            out_pruning_margin <= '0;
            out_cutoff_percent <= '0;
            out_bad_history <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          // one restoring step a cycle
          if (!trial[16]) begin
            rem_r <= trial;
            quo_r <= {quo_r[22:0], 1'b1};
          end else begin
            rem_r <= {rem_r[15:0], quo_r[23]};
            quo_r <= {quo_r[22:0], 1'b0};
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'(mhkt_pkg::DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          logic [6:0] pct;
          pct = (srch_r == 16'd0) ? 7'd0 :
                (quo_r > 24'(mhkt_pkg::PERCENT_MAX)) ? mhkt_pkg::PERCENT_MAX : quo_r[6:0];
          out_killer_hit <= kh_r;
          out_counter_hit <= ch_r;
          out_cutoff_percent <= pct;
          out_pruning_margin <= (srch_r == 16'd0) ? unm_r : pct;
          out_bad_history <= (srch_r != 16'd0) && (pct < thr_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        side;
    logic [6:0]  ply;
    logic [31:0] move;
    logic [2:0]  piece;
    logic [5:0]  square;
    logic        qside;
    logic [2:0]  ppiece;
    logic [5:0]  psquare;
  } move_req_t;

  typedef struct packed {
    logic       killer;
    logic       counter;
    logic [6:0] margin;
    logic [6:0] percent;
    logic       bad;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n, start, busy;
  logic [1:0] in_opcode;
  logic in_side, in_query_prev_side;
  logic [6:0] in_ply_index;
  logic [31:0] in_move_word;
  logic [2:0] in_move_piece, in_prev_piece;
  logic [5:0] in_move_square, in_prev_square;
  logic out_valid, out_killer_hit, out_counter_hit, out_bad_history;
  logic [6:0] out_pruning_margin, out_cutoff_percent;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  move_history_killer_table dut (.*);

  // predictor state
  logic [15:0] hist_searched [mhkt_pkg::HIST_SIZE];
  logic [15:0] hist_cutoffs [mhkt_pkg::HIST_SIZE];
  logic [31:0] killer_a [mhkt_pkg::KILL_SIZE];
  logic [31:0] killer_b [mhkt_pkg::KILL_SIZE];
  logic [31:0] reply_a [mhkt_pkg::HIST_SIZE];
  logic [31:0] reply_b [mhkt_pkg::HIST_SIZE];
  logic [6:0] bad_threshold, unsearched_margin;

  move_req_t pending_reqs[$];
  verdict_t expected_verdicts[$];
  int errors = 0, accepted = 0, verdicts_seen = 0, queries_seen = 0, bad_seen = 0;
  int stall_cycles = 0;
  int idle_left = 0;
  bit idle_enable;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int slot(logic s, logic [2:0] p, logic [5:0] q);
    return (int'(s) * mhkt_pkg::PIECE_KINDS + int'(p) % mhkt_pkg::PIECE_KINDS) * 64 + int'(q);
  endfunction

  function automatic void count_move(int i, bit cut);
    if (hist_searched[i] == 16'hFFFF) begin
      hist_searched[i] = hist_searched[i] >> 4;
      hist_cutoffs[i] = hist_cutoffs[i] >> 4;
    end
    hist_searched[i] = hist_searched[i] + 16'd1;
    if (cut) hist_cutoffs[i] = hist_cutoffs[i] + 16'd1;
  endfunction

  function automatic verdict_t score_move(move_req_t r);
    verdict_t v;
    int h, k, rp, pct;
    v = '0;
    h = slot(r.side, r.piece, r.square);
    k = (int'(r.ply) % mhkt_pkg::PLY_LIMIT) * 2 + int'(r.side);
    if (r.opcode == mhkt_pkg::OP_CUTOFF) begin
      rp = slot(!r.side, r.ppiece, r.psquare);
      count_move(h, 1'b1);
      if (killer_a[k] != r.move) begin
        killer_b[k] = killer_a[k];
        killer_a[k] = r.move;
      end
      if (reply_a[rp] != r.move) begin
        reply_b[rp] = reply_a[rp];
        reply_a[rp] = r.move;
      end
    end else if (r.opcode == mhkt_pkg::OP_QUIET) begin
      count_move(h, 1'b0);
    end else if (r.opcode == mhkt_pkg::OP_QUERY) begin
      rp = slot(r.qside, r.ppiece, r.psquare);
      pct = 0;
      if (hist_searched[h] != 0) begin
        pct = (int'(hist_cutoffs[h]) * 100) / int'(hist_searched[h]);
        if (pct > 100) pct = 100;
      end
      v.killer = (killer_a[k] == r.move) || (killer_b[k] == r.move);
      v.counter = (reply_a[rp] == r.move) || (reply_b[rp] == r.move);
      v.percent = 7'(pct);
      v.margin = (hist_searched[h] == 0) ? unsearched_margin : 7'(pct);
      v.bad = (hist_searched[h] != 0) && (pct < int'(bad_threshold));
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             verdicts_seen);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_opcode <= 0; in_side <= 0; in_ply_index <= 0; in_move_word <= 0;
      in_move_piece <= 0; in_move_square <= 0; in_query_prev_side <= 0;
      in_prev_piece <= 0; in_prev_square <= 0;
      idle_left = 0;
    end else if (start) begin
      // busy was low when start rose, so the request went in at the last rising edge
      start <= 0;
    end else if (!busy && pending_reqs.size() > 0) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 13);
      end else begin
        move_req_t r;
        r = pending_reqs.pop_front();
        in_opcode <= r.opcode; in_side <= r.side; in_ply_index <= r.ply;
        in_move_word <= r.move; in_move_piece <= r.piece; in_move_square <= r.square;
        in_query_prev_side <= r.qside; in_prev_piece <= r.ppiece;
        in_prev_square <= r.psquare;
        start <= 1;
        expected_verdicts.push_back(score_move(r));
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) accepted++;
      if (out_valid) begin
        verdict_t w;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = expected_verdicts.pop_front();
          if (w.margin != 0 || w.percent != 0) queries_seen++;
          if (w.bad) bad_seen++;
          if (out_killer_hit !== w.killer)
            report_mismatch("killer_hit", out_killer_hit, w.killer);
          if (out_counter_hit !== w.counter)
            report_mismatch("counter_hit", out_counter_hit, w.counter);
          if (out_pruning_margin !== w.margin)
            report_mismatch("pruning_margin", out_pruning_margin, w.margin);
          if (out_cutoff_percent !== w.percent)
            report_mismatch("cutoff_percent", out_cutoff_percent, w.percent);
          if (out_bad_history !== w.bad)
            report_mismatch("bad_history", out_bad_history, w.bad);
        end
      end
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[move_history_killer_table] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 3'(idx) << 2; cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == mhkt_pkg::REG_BAD_THRESHOLD) bad_threshold = val;
    else unsearched_margin = val;
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || expected_verdicts.size() > 0 || start) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic move_req_t rand_req(logic [1:0] op);
    move_req_t r;
    r = '0;
    r.opcode = op;
    r.side = 1'($urandom_range(0, 1));
    r.ply = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 3));
    // small move pool so killers and replies hit often
    r.move = $urandom_range(0, 4) == 0 ? $urandom : 32'($urandom_range(0, 7)) << 28 |
             32'($urandom_range(0, 3));
    r.piece = $urandom_range(0, 1) ? 3'($urandom) : 3'($urandom_range(0, 1));
    r.square = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 3));
    r.qside = 1'($urandom_range(0, 1));
    r.ppiece = $urandom_range(0, 1) ? 3'($urandom) : 3'($urandom_range(0, 1));
    r.psquare = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 3));
    return r;
  endfunction

  // non-cutoff siblings, then a cutoff on one move, then a query on that move and a random one
  task automatic queue_search(int quiets);
    move_req_t c, q;
    c = rand_req(mhkt_pkg::OP_CUTOFF);
    for (int i = 0; i < quiets; i++) begin
      q = rand_req(mhkt_pkg::OP_QUIET);
      q.side = c.side;
      if ($urandom_range(0, 1)) begin
        q.piece = c.piece; q.square = c.square;
      end
      pending_reqs.push_back(q);
    end
    pending_reqs.push_back(c);
    q = c;
    q.opcode = mhkt_pkg::OP_QUERY;
    q.qside = !c.side;
    pending_reqs.push_back(q);
    pending_reqs.push_back(rand_req(mhkt_pkg::OP_QUERY));
  endtask

  initial begin
    move_req_t r;
    logic [6:0] thr [4] = '{7'd0, 7'd100, 7'd127, 7'd35};
    logic [6:0] mar [4] = '{7'd0, 7'd127, 7'd100, 7'd51};
    rst_n = 0; idle_enable = 1;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    bad_threshold = mhkt_pkg::BAD_THRESHOLD_RESET;
    unsearched_margin = mhkt_pkg::UNSEARCHED_RESET;
    for (int i = 0; i < mhkt_pkg::HIST_SIZE; i++) begin
      hist_searched[i] = 0; hist_cutoffs[i] = 0; reply_a[i] = 0; reply_b[i] = 0;
    end
    for (int i = 0; i < mhkt_pkg::KILL_SIZE; i++) begin
      killer_a[i] = 0; killer_b[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: unsearched query with reset registers, zero move hits empty slots
    r = '0; r.opcode = mhkt_pkg::OP_QUERY; pending_reqs.push_back(r);
    r = '1; r.opcode = mhkt_pkg::OP_CUTOFF; pending_reqs.push_back(r);
    r.opcode = mhkt_pkg::OP_CUTOFF; pending_reqs.push_back(r);   // same move: no shift
    r.opcode = mhkt_pkg::OP_QUIET; pending_reqs.push_back(r);
    r.opcode = mhkt_pkg::OP_QUERY; r.qside = 0; pending_reqs.push_back(r);
    r.opcode = mhkt_pkg::OP_UNUSED; pending_reqs.push_back(r);
    r = '0; r.opcode = mhkt_pkg::OP_CUTOFF; r.move = 32'h5; r.ply = 7'd127;
    r.piece = 3'd7; r.square = 6'd63; r.ppiece = 3'd7; r.psquare = 6'd63;
    pending_reqs.push_back(r);
    r.move = 32'h6; pending_reqs.push_back(r);
    r.move = 32'h5; r.opcode = mhkt_pkg::OP_QUERY; r.qside = 1; pending_reqs.push_back(r);
    r.move = 32'h7; pending_reqs.push_back(r);
    r.move = 32'h0; pending_reqs.push_back(r);
    for (int i = 0; i < 3; i++) begin
      r.opcode = mhkt_pkg::OP_QUIET; pending_reqs.push_back(r);
    end
    r.opcode = mhkt_pkg::OP_QUERY; pending_reqs.push_back(r);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(mhkt_pkg::REG_BAD_THRESHOLD, thr[phase]);
      write_reg(mhkt_pkg::REG_UNSEARCHED, mar[phase]);
      while (pending_reqs.size() < 370) begin
        if ($urandom_range(0, 4) == 0) pending_reqs.push_back(rand_req(2'($urandom)));
        else queue_search(int'($urandom_range(0, 4)));
      end
      if (phase == 3) idle_enable = 0;
      drain();
    end

    $display("%0d requests accepted, %0d results checked (%0d non-zero queries, %0d bad)",
             accepted, verdicts_seen, queries_seen, bad_seen);
    $display("covered cutoff, quiet, query and unused opcodes under four register settings");
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("[move_history_killer_table] OK");
    end else begin
      $display("[move_history_killer_table] ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mhkt_pkg.sv
hdl/mhkt_ram.sv
hdl/move_history_killer_table.sv
tb/tb_top.sv
